// ===== rtl/core/sla_pkg.sv =====
// Shared constants and types for the semi-Lagrangian advection block.
// No dependencies; imported by grid_semi_lagrangian_advect.
`timescale 1ns / 1ps
`default_nettype none

package sla_pkg;

	// Field widths
	localparam int SAMPLE_W = 16;
	localparam int COORD_W  = 6;

	// Interior size default and reset value of the step scale register (1.0 in Q8.8)
	localparam int                    GRID_N_DEF     = 62;
	localparam logic [SAMPLE_W-1:0]   STEP_SCALE_RST = 16'd256;

	// Store split into four banks by column and row parity
	localparam int NUM_BANKS  = 4;
	localparam int BANK_AW    = 2 * (COORD_W - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;

	// Request codes
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [COORD_W-1:0]         coord_t;

endpackage

`default_nettype wire

// ===== rtl/core/grid_semi_lagrangian_advect.sv =====
// Semi-Lagrangian advection with bilinear interpolation over a banked Q8.8 grid store.
// A query's result passes a 6-register path: stages 1 to 5, then the output register.
// Throughput: one item per cycle when not stalled; the four-bank parity store serves all
// four neighbors in one read. Loads write the store the cycle after acceptance, no result.
// Reset: clears all valid flags and sets step_scale to 1.0; store contents stay undefined.
// Depends on sla_pkg.
`timescale 1ns / 1ps
`default_nettype none

module grid_semi_lagrangian_advect
	import sla_pkg::*;
#(
	parameter int GRID_N = GRID_N_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration
	input  wire logic                step_scale_we,
	input  wire logic [SAMPLE_W-1:0] step_scale_wdata,
	// input channel
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic                req_type,
	input  wire coord_t              cell_col,
	input  wire coord_t              cell_row,
	input  wire sample_t             load_value,
	input  wire sample_t             x_velocity,
	input  wire sample_t             y_velocity,
	// output channel
	output logic                     out_valid,
	input  wire logic                out_stall,
	output sample_t                  result_value,
	output coord_t                   result_col,
	output coord_t                   result_row,
	output logic                     bad_cell
);

	localparam int PROD_W = 2 * SAMPLE_W + 1;   // step (unsigned) * velocity (signed)
	localparam int POS_W  = PROD_W + 2;         // traced position, signed Q.16
	localparam int NCMP_W = 9;                  // holds GRID_N up to its top
	localparam int A_W    = SAMPLE_W + 10;      // sample * 10-bit signed weight
	localparam int C_W    = A_W + 1;
	localparam int M_W    = C_W + 10;
	localparam int SUM_W  = M_W + 1;
	localparam int RND_W  = SUM_W - 16;

	localparam logic signed [POS_W-1:0] LO_LIM = POS_W'(32768);
	localparam logic signed [POS_W-1:0] HI_LIM = POS_W'(GRID_N * 65536 + 32768);
	localparam logic [NCMP_W-1:0]       N_CMP  = NCMP_W'(GRID_N);

	// Configuration register
	logic [SAMPLE_W-1:0] step_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_scale_q <= STEP_SCALE_RST;
		end else if (step_scale_we) begin
			step_scale_q <= step_scale_wdata;
		end
	end

	// Stage advance chain: a stage takes new data when empty or when it drains
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic req_s1;
	logic ld_s1, ld_s2, ld_s3, ld_s4, ld_s5, ld_out;
	logic load_s1;
	logic accept;

	assign ld_out   = !out_valid || !out_stall;
	assign ld_s5    = !v_s5 || ld_out;
	assign ld_s4    = !v_s4 || ld_s5;
	assign ld_s3    = !v_s3 || ld_s4;
	assign ld_s2    = !v_s2 || ld_s3;
	assign load_s1  = v_s1 && (req_s1 == REQ_LOAD);
	assign ld_s1    = !v_s1 || load_s1 || ld_s2;
	assign in_stall = !ld_s1;
	assign accept   = in_valid && ld_s1;

	// Stage 1: capture item, scale both velocities
	logic signed [PROD_W-1:0] prod_x, prod_y;
	logic signed [PROD_W-1:0] prod_x_s1, prod_y_s1;
	coord_t                   col_s1, row_s1;
	sample_t                  load_value_s1;
	logic                     bad_s1;
	logic                     bad_in;

	assign prod_x = $signed({1'b0, step_scale_q}) * x_velocity;
	assign prod_y = $signed({1'b0, step_scale_q}) * y_velocity;
	assign bad_in = (cell_col == '0) || ({3'b0, cell_col} > N_CMP) ||
	                (cell_row == '0) || ({3'b0, cell_row} > N_CMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (ld_s1) begin
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s1) begin
			req_s1        <= req_type;
			col_s1        <= cell_col;
			row_s1        <= cell_row;
			load_value_s1 <= load_value;
			prod_x_s1     <= prod_x;
			prod_y_s1     <= prod_y;
			bad_s1        <= bad_in;
		end
	end

	// Stage 1 logic: trace back, clamp, split into neighbor index and weight
	logic signed [POS_W-1:0] pos_x, pos_y, clp_x, clp_y;
	coord_t                  i0, i1, j0, j1;
	logic [7:0]              sw1, tw1;

	always_comb begin
		pos_x = $signed({{(POS_W-COORD_W-16){1'b0}}, col_s1, 16'b0}) -
		        {{(POS_W-PROD_W){prod_x_s1[PROD_W-1]}}, prod_x_s1};
		pos_y = $signed({{(POS_W-COORD_W-16){1'b0}}, row_s1, 16'b0}) -
		        {{(POS_W-PROD_W){prod_y_s1[PROD_W-1]}}, prod_y_s1};
		priority if (pos_x < LO_LIM) clp_x = LO_LIM;
		else if (pos_x > HI_LIM)     clp_x = HI_LIM;
		else                         clp_x = pos_x;
		priority if (pos_y < LO_LIM) clp_y = LO_LIM;
		else if (pos_y > HI_LIM)     clp_y = HI_LIM;
		else                         clp_y = pos_y;
	end

	// neighbor coordinates wrap to the store side
	assign i0  = clp_x[16 +: COORD_W];
	assign j0  = clp_y[16 +: COORD_W];
	assign i1  = i0 + COORD_W'(1);
	assign j1  = j0 + COORD_W'(1);
	assign sw1 = clp_x[15:8];
	assign tw1 = clp_y[15:8];

	// Banked store: bank index is {row parity, col parity}
	logic [BANK_AW-1:0]     rd_addr [NUM_BANKS];
	sample_t                bank_rd [NUM_BANKS];
	logic [1:0]             wr_bank;
	logic [BANK_AW-1:0]     wr_addr;

	assign wr_bank = {row_s1[0], col_s1[0]};
	assign wr_addr = {row_s1[COORD_W-1:1], col_s1[COORD_W-1:1]};

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		localparam logic PC = 1'(b);
		localparam logic PR = 1'(b >> 1);
		sample_t mem [BANK_DEPTH];
		sample_t rdata_s2;
		coord_t  bcol, brow;

		// pick whichever of the two neighbors has this bank's parity
		assign bcol       = (i0[0] == PC) ? i0 : i1;
		assign brow       = (j0[0] == PR) ? j0 : j1;
		assign rd_addr[b] = {brow[COORD_W-1:1], bcol[COORD_W-1:1]};
		assign bank_rd[b] = rdata_s2;

		always_ff @(posedge clk) begin
			if (load_s1 && (wr_bank == 2'(b))) begin
				mem[wr_addr] <= load_value_s1;
			end
			if (ld_s2) begin
				rdata_s2 <= mem[rd_addr[b]];
			end
		end
	end

	// Stage 2: neighbor data arrives
	coord_t     col_s2, row_s2;
	logic       bad_s2, i0p_s2, j0p_s2;
	logic [7:0] sw_s2, tw_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (ld_s2) begin
			v_s2 <= v_s1 && (req_s1 == REQ_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			col_s2 <= col_s1;
			row_s2 <= row_s1;
			bad_s2 <= bad_s1;
			i0p_s2 <= i0[0];
			j0p_s2 <= j0[0];
			sw_s2  <= sw1;
			tw_s2  <= tw1;
		end
	end

	// Stage 2 logic: route banks to corners, weight along rows
	sample_t                v00, v01, v10, v11;
	logic signed [9:0]      t0w, t1w;
	logic signed [A_W-1:0]  a00, a01, a10, a11;

	assign v00 = bank_rd[{j0p_s2, i0p_s2}];
	assign v10 = bank_rd[{j0p_s2, ~i0p_s2}];
	assign v01 = bank_rd[{~j0p_s2, i0p_s2}];
	assign v11 = bank_rd[{~j0p_s2, ~i0p_s2}];
	assign t1w = $signed({2'b0, tw_s2});
	assign t0w = 10'sd256 - t1w;
	assign a00 = v00 * t0w;
	assign a01 = v01 * t1w;
	assign a10 = v10 * t0w;
	assign a11 = v11 * t1w;

	// Stage 3: row-weighted corner products
	logic signed [A_W-1:0] a00_s3, a01_s3, a10_s3, a11_s3;
	coord_t                col_s3, row_s3;
	logic                  bad_s3;
	logic [7:0]            sw_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (ld_s3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			a00_s3 <= a00;
			a01_s3 <= a01;
			a10_s3 <= a10;
			a11_s3 <= a11;
			col_s3 <= col_s2;
			row_s3 <= row_s2;
			bad_s3 <= bad_s2;
			sw_s3  <= sw_s2;
		end
	end

	// Stage 4: column sums
	logic signed [C_W-1:0] c0_s4, c1_s4;
	coord_t                col_s4, row_s4;
	logic                  bad_s4;
	logic [7:0]            sw_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (ld_s4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s4) begin
			c0_s4  <= C_W'(a00_s3) + C_W'(a01_s3);
			c1_s4  <= C_W'(a10_s3) + C_W'(a11_s3);
			col_s4 <= col_s3;
			row_s4 <= row_s3;
			bad_s4 <= bad_s3;
			sw_s4  <= sw_s3;
		end
	end

	// Stage 4 logic: weight along columns
	logic signed [9:0]     s0w, s1w;
	logic signed [M_W-1:0] m0, m1;

	assign s1w = $signed({2'b0, sw_s4});
	assign s0w = 10'sd256 - s1w;
	assign m0  = c0_s4 * s0w;
	assign m1  = c1_s4 * s1w;

	// Stage 5: weighted column terms
	logic signed [M_W-1:0] m0_s5, m1_s5;
	coord_t                col_s5, row_s5;
	logic                  bad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (ld_s5) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s5) begin
			m0_s5  <= m0;
			m1_s5  <= m1;
			col_s5 <= col_s4;
			row_s5 <= row_s4;
			bad_s5 <= bad_s4;
		end
	end

	// Stage 5 logic: sum, round half up, drop 16 fraction bits, saturate
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] sum_rnd;
	logic signed [RND_W-1:0] rnd;
	sample_t                 sat;

	always_comb begin
		sum     = SUM_W'(m0_s5) + SUM_W'(m1_s5);
		sum_rnd = sum + SUM_W'(32768);
		rnd     = sum_rnd[SUM_W-1:16];
		priority if (rnd > RND_W'(32767))   sat = 16'sh7fff;
		else if (rnd < -RND_W'(32768))      sat = 16'sh8000;
		else                                sat = rnd[SAMPLE_W-1:0];
	end

	// Output register
	logic out_valid_q;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ld_out) begin
			out_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out) begin
			result_value <= bad_s5 ? '0 : sat;
			result_col   <= col_s5;
			result_row   <= row_s5;
			bad_cell     <= bad_s5;
		end
	end

endmodule

`default_nettype wire
